// ===== hw/rtl/rcn_pkg.sv =====
// Shared types and constants of the radio channel normalizer.
package rcn_pkg;

  // Fixed channel layout of the radio link
  localparam int CHANNEL_COUNT = 16;
  localparam int STICK_COUNT   = 4;
  localparam logic [5:0] CH_LIM    = 6'(CHANNEL_COUNT);
  localparam logic [4:0] STICK_LIM = 5'(STICK_COUNT);

  localparam logic [14:0] Q_ONE   = 15'd16384;
  localparam logic [16:0] AGE_MAX = 17'h1FFFF;

  // Quotient bits below full scale; one per divider step
  localparam int DIV_STEPS = 14;

  // Queue between front and back
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    REG_STICK_MIN = 3'd0,
    REG_STICK_MID = 3'd1,
    REG_STICK_MAX = 3'd2,
    REG_AUX_MIN   = 3'd3,
    REG_AUX_MID   = 3'd4,
    REG_AUX_MAX   = 3'd5,
    REG_DEADZONE  = 3'd6,
    REG_TIMEOUT   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic        func;
    logic [3:0]  channel_index;
    logic [10:0] raw_value;
    logic        frame_failsafe;
    logic        frame_lost_flag;
    logic        last_channel;
  } item_t;

  typedef struct packed {
    logic [3:0]         out_channel;
    logic [10:0]        raw_echo;
    logic signed [15:0] norm_value;
    logic               signal_valid;
    logic               failsafe_state;
    logic               lost_state;
    logic [31:0]        frames_received;
  } result_t;

  typedef struct packed {
    logic        signal_valid;
    logic        failsafe_state;
    logic        lost_state;
    logic [31:0] frames_received;
  } status_t;

  // One classified item on its way from front to back
  typedef struct packed {
    logic        func;
    logic [3:0]  channel;
    logic [10:0] raw;
    logic        stick;
    status_t     status;
  } work_t;

  typedef struct packed {
    logic [10:0] lo;
    logic [10:0] mid;
    logic [10:0] hi;
  } cal_t;

  typedef struct packed {
    cal_t        stick;
    cal_t        aux;
    logic [14:0] deadzone;
  } cfg_t;

endpackage

// ===== hw/rtl/rcn_front.sv =====
// Front end: accepts items, tracks link state and classifies channels.
module rcn_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  rcn_pkg::item_t item,
  input  logic [15:0]    timeout_ticks,
  input  logic           queue_full,
  output logic           push,
  output rcn_pkg::work_t entry
);
  import rcn_pkg::*;

  logic        valid_flag, valid_flag_next;
  logic        failsafe_flag, failsafe_flag_next;
  logic        lost_flag, lost_flag_next;
  logic [31:0] frame_counter, frame_counter_next;
  logic [16:0] age_ticks, age_ticks_next;

  assign item_ready = !queue_full;
  assign push       = item_valid && item_ready;

  always_comb begin
    valid_flag_next    = valid_flag;
    failsafe_flag_next = failsafe_flag;
    lost_flag_next     = lost_flag;
    frame_counter_next = frame_counter;
    age_ticks_next     = age_ticks;
    if (item.func) begin
      if (age_ticks != AGE_MAX) age_ticks_next = age_ticks + 17'd1;
    end else if (item.last_channel) begin
      failsafe_flag_next = item.frame_failsafe;
      lost_flag_next     = item.frame_lost_flag;
      frame_counter_next = frame_counter + 32'd1;
      if (!item.frame_lost_flag) begin
        valid_flag_next = 1'b1;
        age_ticks_next  = '0;
      end
    end
    // timeout is checked after every item, value items included
    if (valid_flag_next && (age_ticks_next > {1'b0, timeout_ticks})) begin
      valid_flag_next    = 1'b0;
      failsafe_flag_next = 1'b1;
    end
  end

  always_comb begin
    entry.func    = item.func;
    entry.channel = item.channel_index;
    entry.raw     = item.raw_value;
    entry.stick   = ({1'b0, item.channel_index} < STICK_LIM) &&
                    ({2'b0, item.channel_index} < CH_LIM);
    entry.status.signal_valid    = valid_flag_next;
    entry.status.failsafe_state  = failsafe_flag_next;
    entry.status.lost_state      = lost_flag_next;
    entry.status.frames_received = frame_counter_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_flag    <= 1'b0;
      failsafe_flag <= 1'b1;
      lost_flag     <= 1'b1;
      frame_counter <= '0;
      age_ticks     <= '0;
    end else if (push) begin
      valid_flag    <= valid_flag_next;
      failsafe_flag <= failsafe_flag_next;
      lost_flag     <= lost_flag_next;
      frame_counter <= frame_counter_next;
      age_ticks     <= age_ticks_next;
    end
  end

endmodule

// ===== hw/rtl/rcn_queue.sv =====
// Short FIFO between the front end and the back end.
module rcn_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcn_pkg::work_t push_data,
  input  logic           pop,
  output rcn_pkg::work_t pop_data,
  output logic           full,
  output logic           empty
);
  import rcn_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  work_t         slots [QDEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full     = (count == (PW+1)'(QDEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QDEPTH-1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(QDEPTH-1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + (PW+1)'(1);
      else if (pop && !push) count <= count - (PW+1)'(1);
    end
  end

endmodule

// ===== hw/rtl/rcn_back.sv =====
// Back end: clamp, restoring divide, deadzone and result register.
module rcn_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_empty,
  input  rcn_pkg::work_t   q_data,
  output logic             pop,
  input  rcn_pkg::cfg_t    cfg,
  output logic             result_valid,
  input  logic             result_ready,
  output rcn_pkg::result_t result
);
  import rcn_pkg::*;

  localparam int SW = $clog2(DIV_STEPS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t      state;
  work_t       cur;
  logic [10:0] rem, den;
  logic [14:0] mag;
  logic        neg;
  logic [SW-1:0] step;

  // setup terms
  cal_t        cal;
  logic [10:0] r1, r2, num;
  logic [11:0] den_s;
  logic        below, above, den_ok, sat;

  // divider step
  logic [11:0] rem_sh, rem_dif;
  logic        fits;

  // output
  logic [14:0] mag_dz;
  logic [15:0] mag_ext;
  logic        load;

  always_comb begin
    cal    = cur.stick ? cfg.stick : cfg.aux;
    r1     = (cur.raw < cal.lo) ? cal.lo : cur.raw;
    r2     = (r1 > cal.hi) ? cal.hi : r1;   // max wins on inverted calibration
    below  = r2 < cal.mid;
    above  = r2 > cal.mid;
    num    = below ? (cal.mid - r2) : (r2 - cal.mid);
    den_s  = below ? ({1'b0, cal.mid} - {1'b0, cal.lo})
                   : ({1'b0, cal.hi} - {1'b0, cal.mid});
    den_ok = !den_s[11] && (den_s[10:0] != 11'd0);
    sat    = num >= den_s[10:0];
  end

  always_comb begin
    rem_sh  = {rem, 1'b0};
    fits    = rem_sh >= {1'b0, den};
    rem_dif = rem_sh - {1'b0, den};
  end

  always_comb begin
    mag_dz  = (mag < cfg.deadzone) ? '0 : mag;
    mag_ext = {1'b0, mag_dz};
    load    = (state == S_DONE) && (!result_valid || result_ready);
    pop     = (state == S_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!q_empty) state <= S_CALC;
        end
        S_CALC: begin
          if (cur.func || !(below || above) || !den_ok || sat) state <= S_DONE;
          else state <= S_DIV;
        end
        S_DIV: begin
          if (step == SW'(DIV_STEPS-1)) state <= S_DONE;
        end
        S_DONE: begin
          if (load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_data;
    if (state == S_CALC) begin
      neg  <= below ^ cur.stick;
      rem  <= num;
      den  <= den_s[10:0];
      step <= '0;
      if (cur.func || !(below || above)) mag <= '0;
      else if (!den_ok || sat)           mag <= Q_ONE;
      else                               mag <= '0;
    end
    if (state == S_DIV) begin
      rem  <= fits ? rem_dif[10:0] : rem_sh[10:0];
      mag  <= {mag[13:0], fits};
      step <= step + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else if (load) result_valid <= 1'b1;
    else if (result_ready) result_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.out_channel     <= cur.func ? 4'd0 : cur.channel;
      result.raw_echo        <= cur.func ? 11'd0 : cur.raw;
      result.norm_value      <= neg ? 16'(-mag_ext) : mag_ext;
      result.signal_valid    <= cur.status.signal_valid;
      result.failsafe_state  <= cur.status.failsafe_state;
      result.lost_state      <= cur.status.lost_state;
      result.frames_received <= cur.status.frames_received;
    end
  end

endmodule

// ===== hw/rtl/rc_channel_normalizer.sv =====
// From acceptance an item passes the queue, back-end states idle and calc, the 14-step
// restoring divider for a value item that needs it (not for a tick or a value item
// at mid or full scale), done and the result register; the back end holds one item
// at a time; a 2-entry queue lets the front accept while a result waits to be taken.
// Reset (synchronous, active high): link state to invalid, failsafe and lost set, frame
// count and age zero, queue and result register empty, calibration to defaults.
module rc_channel_normalizer (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  rcn_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output rcn_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [4:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import rcn_pkg::*;

  cfg_t        cfg;
  logic [15:0] timeout_ticks;
  reg_idx_t    reg_idx;
  logic        wr_en;

  logic        push, pop, q_full, q_empty;
  work_t       push_data, pop_data;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stick.lo  <= 11'd172;
      cfg.stick.mid <= 11'd992;
      cfg.stick.hi  <= 11'd1811;
      cfg.aux.lo    <= 11'd172;
      cfg.aux.mid   <= 11'd992;
      cfg.aux.hi    <= 11'd1811;
      cfg.deadzone  <= '0;
      timeout_ticks <= 16'd100;
    end else if (wr_en) begin
      case (reg_idx)
        REG_STICK_MIN: cfg.stick.lo  <= pwdata[10:0];
        REG_STICK_MID: cfg.stick.mid <= pwdata[10:0];
        REG_STICK_MAX: cfg.stick.hi  <= pwdata[10:0];
        REG_AUX_MIN:   cfg.aux.lo    <= pwdata[10:0];
        REG_AUX_MID:   cfg.aux.mid   <= pwdata[10:0];
        REG_AUX_MAX:   cfg.aux.hi    <= pwdata[10:0];
        REG_DEADZONE:  cfg.deadzone  <= pwdata[14:0];
        REG_TIMEOUT:   timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STICK_MIN: prdata = {21'd0, cfg.stick.lo};
      REG_STICK_MID: prdata = {21'd0, cfg.stick.mid};
      REG_STICK_MAX: prdata = {21'd0, cfg.stick.hi};
      REG_AUX_MIN:   prdata = {21'd0, cfg.aux.lo};
      REG_AUX_MID:   prdata = {21'd0, cfg.aux.mid};
      REG_AUX_MAX:   prdata = {21'd0, cfg.aux.hi};
      REG_DEADZONE:  prdata = {17'd0, cfg.deadzone};
      REG_TIMEOUT:   prdata = {16'd0, timeout_ticks};
      default:       prdata = '0;
    endcase
  end

  rcn_front u_front (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (item_valid),
    .item_ready    (item_ready),
    .item          (item),
    .timeout_ticks (timeout_ticks),
    .queue_full    (q_full),
    .push          (push),
    .entry         (push_data)
  );

  rcn_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .full      (q_full),
    .empty     (q_empty)
  );

  rcn_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_data       (pop_data),
    .pop          (pop),
    .cfg          (cfg),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ===== hw/rtl/rcn_check.sv =====
// Port-level checker for the normalizer, bound to the top level.
module rcn_check (
  input logic             clk,
  input logic             rst,
  input logic             item_ready,
  input logic             result_valid,
  input logic             result_ready,
  input rcn_pkg::result_t result,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [4:0]       paddr,
  input logic [31:0]      pwdata,
  input logic [31:0]      prdata,
  input logic             pready
);
  import rcn_pkg::*;

  // reset empties the result register and the queue
  a_rst_out: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  a_rst_in: assert property (@(posedge clk) rst |=> item_ready)
    else $error("input not ready after reset");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result_ready) |=> (result_valid && $stable(result)))
    else $error("stalled result changed");

  // normalized value stays within plus/minus one
  a_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.norm_value <= 16'sd16384 &&
                      result.norm_value >= -16'sd16384))
    else $error("norm_value out of range");

  // timeout register reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && paddr[4:2] == REG_TIMEOUT) ##1
    (paddr == $past(paddr)) |-> (prdata == {16'd0, $past(pwdata[15:0])}))
    else $error("timeout readback mismatch");

endmodule

bind rc_channel_normalizer rcn_check u_check (.*);
